/* src/lc3b_pkg.sv */
`default_nettype none

package lc3b_pkg;

  // word memory depth, a power of two from 256 to 32768
  localparam int MEM_WORDS = 32768;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EXEC = 1'b1;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LDB  = 4'd2;
  localparam logic [3:0] OP_STB  = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDW  = 4'd6;
  localparam logic [3:0] OP_STW  = 4'd7;
  localparam logic [3:0] OP_XOR  = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_SHF  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [2:0] CC_RESET = 3'b010;
  localparam logic [2:0] LINK_REG = 3'd7;

  typedef struct packed {
    logic clear;    // clearing pass step
    logic accept;   // input transfer this cycle
    logic fetch;    // halt check and instruction read
    logic decode;   // latch instruction, read base register
    logic read_b;   // latch base, read second register
    logic exec;     // compute, issue data read
    logic commit;   // write back
    logic capture;  // load output register
  } lc3b_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pc_zero;
    logic halted;
  } lc3b_stat_t;

endpackage

`default_nettype wire

/* src/lc3b_if.sv */
`default_nettype none

interface lc3b_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [14:0] mem_word_address;
  logic [15:0] mem_word_data;

  modport source (output valid, cmd, mem_word_address, mem_word_data, input ready);
  modport sink   (input valid, cmd, mem_word_address, mem_word_data, output ready);
endinterface

interface lc3b_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] program_counter;
  logic [2:0]  cond_codes;
  logic        halted;
  logic [31:0] executed_count;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;

  modport source (output valid, program_counter, cond_codes, halted, executed_count,
                  reg_written, reg_index, reg_value, input ready);
  modport sink   (input valid, program_counter, cond_codes, halted, executed_count,
                  reg_written, reg_index, reg_value, output ready);
endinterface

`default_nettype wire

/* src/lc3b_ctrl.sv */
`default_nettype none

module lc3b_ctrl
  import lc3b_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_cmd,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire lc3b_stat_t stat,
  output lc3b_cmd_t       cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_RB    = 3'd4;
  localparam logic [2:0] S_EX    = 3'd5;
  localparam logic [2:0] S_MEM   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (in_cmd == CMD_EXEC && !stat.halted) ? S_FETCH : S_DONE;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = stat.pc_zero ? S_DONE : S_DEC;
      end
      S_DEC: begin
        cmd.decode = 1'b1;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.read_b = 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        cmd.exec   = 1'b1;
        state_next = S_MEM;
      end
      S_MEM: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* src/lc3b_dp.sv */
`default_nettype none

module lc3b_dp
  import lc3b_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_pc_we,
  input  wire logic [15:0] start_pc_wdata,
  input  wire logic        in_cmd,
  input  wire logic [14:0] in_addr,
  input  wire logic [15:0] in_data,
  input  wire lc3b_cmd_t   cmd,
  output lc3b_stat_t       stat,
  output logic [15:0]      program_counter,
  output logic [2:0]       cond_codes,
  output logic             halted,
  output logic [31:0]      executed_count,
  output logic             reg_written,
  output logic [2:0]       reg_index,
  output logic [15:0]      reg_value
);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rf [8];

  logic [15:0] start_pc;
  logic [15:0] pc;
  logic [2:0]  cc;
  logic        halt;
  logic        started;
  logic [31:0] count;
  logic [MEM_AW-1:0] clr_idx;

  logic [15:0] ir;
  logic [15:0] a_q;
  logic [15:0] rf_q;
  logic [15:0] mem_q;
  logic [15:0] addr_q;
  logic [15:0] val_q;
  logic [15:0] next_q;
  logic        exw_q;
  logic [2:0]  exri_q;
  logic        setcc_q;
  logic        wr_q;
  logic [2:0]  ri_q;
  logic [15:0] rv_q;

  logic [3:0]  op;
  logic [2:0]  dr;
  logic        is_store;
  logic [15:0] npc;
  logic [15:0] off6;
  logic [15:0] off9;
  logic [15:0] off11;
  logic [15:0] b_op;
  logic [15:0] eaddr;
  logic [15:0] val_n;
  logic [15:0] next_n;
  logic        wr_n;
  logic [2:0]  ri_n;
  logic        setcc_n;
  logic [15:0] fval;
  logic [15:0] fnext;
  logic [7:0]  byte_sel;

  logic [2:0]        rf_ra;
  logic [MEM_AW-1:0] mem_ra;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [15:0]       mem_wd;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    if (v == 16'h0000) return 3'b010;
    return 3'b001;
  endfunction

  assign op       = ir[15:12];
  assign dr       = ir[11:9];
  assign is_store = op inside {OP_STB, OP_STW};
  assign npc      = pc + 16'd2;
  assign off6     = {{10{ir[5]}}, ir[5:0]};
  assign off9     = {{6{ir[8]}}, ir[8:0], 1'b0};
  assign off11    = {{4{ir[10]}}, ir[10:0], 1'b0};
  assign b_op     = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf_q;
  assign eaddr    = (op inside {OP_LDW, OP_STW}) ? a_q + {off6[14:0], 1'b0} : a_q + off6;

  // execute stage
  always_comb begin
    val_n   = '0;
    next_n  = npc;
    wr_n    = 1'b0;
    ri_n    = dr;
    setcc_n = 1'b0;
    case (op)
      OP_ADD: begin val_n = a_q + b_op; wr_n = 1'b1; setcc_n = 1'b1; end
      OP_AND: begin val_n = a_q & b_op; wr_n = 1'b1; setcc_n = 1'b1; end
      OP_XOR: begin val_n = a_q ^ b_op; wr_n = 1'b1; setcc_n = 1'b1; end
      OP_BR: begin
        if ((dr & cc) != 3'b000) next_n = npc + off9;
      end
      OP_JMP: next_n = a_q;
      OP_JSR: begin
        next_n = ir[11] ? npc + off11 : a_q;
        val_n  = npc;
        wr_n   = 1'b1;
        ri_n   = LINK_REG;
      end
      OP_LDB, OP_LDW: begin wr_n = 1'b1; setcc_n = 1'b1; end
      OP_LEA: begin val_n = npc + off9; wr_n = 1'b1; end
      OP_SHF: begin
        if (!ir[4]) val_n = a_q << ir[3:0];
        else if (ir[5]) val_n = 16'($signed(a_q) >>> ir[3:0]);
        else val_n = a_q >> ir[3:0];
        wr_n    = 1'b1;
        setcc_n = 1'b1;
      end
      OP_TRAP: begin val_n = npc; wr_n = 1'b1; ri_n = LINK_REG; end
      default: ;
    endcase
  end

  // write-back stage
  assign byte_sel = addr_q[0] ? mem_q[15:8] : mem_q[7:0];
  always_comb begin
    case (op)
      OP_LDB:  fval = {{8{byte_sel[7]}}, byte_sel};
      OP_LDW:  fval = mem_q;
      default: fval = val_q;
    endcase
    fnext = (op == OP_TRAP) ? mem_q : next_q;
  end

  // memory ports
  always_comb begin
    if (cmd.fetch) mem_ra = pc[MEM_AW:1];
    else if (op == OP_TRAP) mem_ra = MEM_AW'(ir[7:0]);
    else mem_ra = eaddr[MEM_AW:1];

    mem_we = 1'b0;
    mem_wa = clr_idx;
    mem_wd = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.accept && in_cmd == CMD_LOAD) begin
      mem_we = 1'b1;
      mem_wa = in_addr[MEM_AW-1:0];
      mem_wd = in_data;
    end else if (cmd.commit && is_store) begin
      mem_we = 1'b1;
      mem_wa = addr_q[MEM_AW:1];
      if (op == OP_STW) mem_wd = rf_q;
      else if (addr_q[0]) mem_wd = {rf_q[7:0], mem_q[7:0]};
      else mem_wd = {mem_q[15:8], rf_q[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  assign rf_ra = cmd.decode ? mem_q[8:6] : (is_store ? dr : ir[2:0]);

  always_ff @(posedge clk) begin
    if (cmd.clear) rf[clr_idx[2:0]] <= '0;
    else if (cmd.commit && exw_q) rf[exri_q] <= fval;
    rf_q <= rf[rf_ra];
  end

  // instruction pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.decode) ir <= mem_q;
    if (cmd.read_b) a_q <= rf_q;
    if (cmd.exec) begin
      addr_q  <= eaddr;
      val_q   <= val_n;
      next_q  <= next_n;
      exw_q   <= wr_n;
      exri_q  <= ri_n;
      setcc_q <= setcc_n;
    end
    if (cmd.capture) begin
      program_counter <= pc;
      cond_codes      <= cc;
      halted          <= halt;
      executed_count  <= count;
      reg_written     <= wr_q;
      reg_index       <= ri_q;
      reg_value       <= rv_q;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= '0;
      pc       <= '0;
      cc       <= CC_RESET;
      halt     <= 1'b0;
      started  <= 1'b0;
      count    <= '0;
      clr_idx  <= '0;
      wr_q     <= 1'b0;
      ri_q     <= '0;
      rv_q     <= '0;
    end else begin
      if (start_pc_we) start_pc <= start_pc_wdata;
      if (cmd.clear) clr_idx <= clr_idx + 1'b1;
      if (cmd.accept) begin
        wr_q <= 1'b0;
        ri_q <= '0;
        rv_q <= '0;
        if (in_cmd == CMD_EXEC && !halt && !started) begin
          pc      <= start_pc;
          started <= 1'b1;
        end
      end
      if (cmd.fetch && pc == 16'h0000) halt <= 1'b1;
      if (cmd.commit) begin
        pc    <= fnext;
        count <= count + 32'd1;
        if (setcc_q) cc <= cc_of(fval);
        if (exw_q) begin
          wr_q <= 1'b1;
          ri_q <= exri_q;
          rv_q <= fval;
        end
      end
    end
  end

  assign stat.clear_last = (clr_idx == MEM_AW'(MEM_WORDS - 1));
  assign stat.pc_zero    = (pc == 16'h0000);
  assign stat.halted     = halt;

endmodule

`default_nettype wire

/* src/lc3b_instruction_execute.sv */
`default_nettype none

// channel  dir  payload                                           transfer when
// in_ch    in   cmd, mem_word_address, mem_word_data              valid && ready
// out_ch   out  program_counter, cond_codes, halted, count, reg   valid && ready
// start_pc in   start_pc_wdata, single register                   start_pc_we
//
// a load runs idle, done; an instruction idle, fetch, decode, read, exec, commit, done;
// a halted step ends in done from idle, or from fetch at pc zero; the one memory read port
// serves fetch, then a data or trap read; reset clears all MEM_WORDS (32768) words, in_ch.ready low
// an item is taken only in idle; a finished result waits in the output register
// and the next item is accepted while it waits, the core stalls at completion only

module lc3b_instruction_execute
  import lc3b_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_pc_we,
  input  wire logic [15:0] start_pc_wdata,
  lc3b_in_if.sink          in_ch,
  lc3b_out_if.source       out_ch
);

  // command and status between controller and datapath
  lc3b_cmd_t  cmd;
  lc3b_stat_t stat;

  // sequencer: clear pass, idle, fetch, decode, operand read, execute, write back, done
  lc3b_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // register file, word memory, alu and the output register
  lc3b_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .start_pc_we     (start_pc_we),
    .start_pc_wdata  (start_pc_wdata),
    .in_cmd          (in_ch.cmd),
    .in_addr         (in_ch.mem_word_address),
    .in_data         (in_ch.mem_word_data),
    .cmd             (cmd),
    .stat            (stat),
    .program_counter (out_ch.program_counter),
    .cond_codes      (out_ch.cond_codes),
    .halted          (out_ch.halted),
    .executed_count  (out_ch.executed_count),
    .reg_written     (out_ch.reg_written),
    .reg_index       (out_ch.reg_index),
    .reg_value       (out_ch.reg_value)
  );

`ifndef SYNTHESIS
  // the halted flag is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) !$fell(stat.halted))
    else $error("halted flag dropped");

  // output register never overwritten while a result waits
  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten");

  // one item in flight: no transfer in the cycle after an input transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire

/* bench/tb_lc3b_instruction_execute.sv */
`default_nettype none

module tb_lc3b_instruction_execute;
  import lc3b_pkg::*;

  // opcodes with no defined behaviour, they only advance the pc
  localparam logic [3:0] OP_RSV8  = 4'd8;
  localparam logic [3:0] OP_RSV10 = 4'd10;
  localparam logic [3:0] OP_RSV11 = 4'd11;
  localparam int IDLE_LIMIT = 200000;  // covers the clearing pass after reset

  typedef struct {
    logic        cmd;
    logic [14:0] wa;
    logic [15:0] wd;
    int          gap;
  } core_item_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [2:0]  cc;
    logic        halted;
    logic [31:0] count;
    logic        wr;
    logic [2:0]  ri;
    logic [15:0] rv;
  } core_state_t;

  logic clk, rst;
  logic start_pc_we;
  logic [15:0] start_pc_wdata;

  lc3b_in_if  in_ch();
  lc3b_out_if out_ch();

  lc3b_instruction_execute dut (
    .clk(clk), .rst(rst),
    .start_pc_we(start_pc_we), .start_pc_wdata(start_pc_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // shadow copy of the core
  logic [15:0] sh_mem [MEM_WORDS];
  logic [15:0] sh_regs [8];
  logic [15:0] sh_pc;
  logic [2:0]  sh_nzp;
  logic        sh_halt, sh_started;
  logic [31:0] sh_count;
  logic [15:0] sh_start_pc;

  core_item_t  pending_q[$];
  core_state_t awaited_q[$];

  bit in_fire, out_fire;
  bit calm;           // phase with no idling on either side
  int rdy_wait;
  int mismatches;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned widx(logic [15:0] ad);
    return (ad >> 1) % MEM_WORDS;
  endfunction

  // works out the result of one item; with apply clear it leaves the shadow untouched
  function automatic core_state_t core_step(logic cmd, logic [14:0] wa, logic [15:0] wd,
                                            bit apply);
    core_state_t r;
    logic [15:0] pc, ir, npc, nxt, a, b, val, addr, w, st_data;
    logic [7:0]  bt;
    logic [3:0]  op;
    logic [2:0]  dr, ri, cc;
    bit          wr, setcc, st, halt, started;
    int unsigned st_k;
    logic [31:0] count;
    pc = sh_started ? sh_pc : sh_start_pc;
    cc = sh_nzp; halt = sh_halt; started = sh_started; count = sh_count;
    wr = 0; setcc = 0; st = 0; val = '0; ri = '0; nxt = sh_pc; st_k = 0; st_data = '0;
    if (cmd == CMD_LOAD) begin
      if (apply) sh_mem[wa % MEM_WORDS] = wd;
    end else if (!halt) begin
      started = 1;
      nxt = pc;
      if (pc == 16'h0000) begin
        halt = 1;
      end else begin
        ir = sh_mem[widx(pc)];
        op = ir[15:12]; dr = ir[11:9];
        npc = pc + 16'd2; nxt = npc;
        a = sh_regs[ir[8:6]];
        case (op)
          OP_ADD, OP_AND, OP_XOR: begin
            b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : sh_regs[ir[2:0]];
            val = (op == OP_ADD) ? a + b : (op == OP_AND) ? (a & b) : (a ^ b);
            wr = 1; ri = dr; setcc = 1;
          end
          OP_BR: if ((dr & cc) != 3'b000) nxt = npc + {{6{ir[8]}}, ir[8:0], 1'b0};
          OP_JMP: nxt = a;
          OP_JSR: begin
            nxt = ir[11] ? npc + {{4{ir[10]}}, ir[10:0], 1'b0} : a;
            val = npc; wr = 1; ri = LINK_REG;
          end
          OP_LDB: begin
            addr = a + {{10{ir[5]}}, ir[5:0]};
            w = sh_mem[widx(addr)];
            bt = addr[0] ? w[15:8] : w[7:0];
            val = {{8{bt[7]}}, bt}; wr = 1; ri = dr; setcc = 1;
          end
          OP_LDW: begin
            addr = a + {{9{ir[5]}}, ir[5:0], 1'b0};
            val = sh_mem[widx(addr)]; wr = 1; ri = dr; setcc = 1;
          end
          OP_LEA: begin
            val = npc + {{6{ir[8]}}, ir[8:0], 1'b0}; wr = 1; ri = dr;
          end
          OP_SHF: begin
            if (!ir[4]) val = a << ir[3:0];
            else if (ir[5]) val = 16'($signed(a) >>> ir[3:0]);
            else val = a >> ir[3:0];
            wr = 1; ri = dr; setcc = 1;
          end
          OP_STB: begin
            addr = a + {{10{ir[5]}}, ir[5:0]};
            st_k = widx(addr); w = sh_mem[st_k];
            st_data = addr[0] ? {sh_regs[dr][7:0], w[7:0]} : {w[15:8], sh_regs[dr][7:0]};
            st = 1;
          end
          OP_STW: begin
            addr = a + {{9{ir[5]}}, ir[5:0], 1'b0};
            st_k = widx(addr); st_data = sh_regs[dr]; st = 1;
          end
          OP_TRAP: begin
            nxt = sh_mem[widx({7'd0, ir[7:0], 1'b0})];
            val = npc; wr = 1; ri = LINK_REG;
          end
          default: ;
        endcase
        if (setcc) cc = val[15] ? 3'b100 : (val == 16'h0000) ? 3'b010 : 3'b001;
        count = count + 1;
      end
      if (apply) begin
        if (wr) sh_regs[ri] = val;
        if (st) sh_mem[st_k] = st_data;
        sh_pc = nxt; sh_nzp = cc; sh_halt = halt; sh_started = started; sh_count = count;
      end
    end
    r.pc = (cmd == CMD_LOAD) ? sh_pc : nxt;
    r.cc = cc; r.halted = halt; r.count = count;
    r.wr = wr; r.ri = wr ? ri : 3'd0; r.rv = wr ? val : 16'd0;
    return r;
  endfunction

  task automatic queue_item(logic cmd, logic [14:0] wa, logic [15:0] wd);
    core_item_t it;
    it.cmd = cmd; it.wa = wa; it.wd = wd;
    it.gap = calm ? 0 : $urandom_range(0, 15);
    awaited_q.push_back(core_step(cmd, wa, wd, 1));
    pending_q.push_back(it);
  endtask

  // would executing this word at the current pc leave the pc at zero
  function automatic bit lands_on_zero(logic [15:0] word);
    int unsigned k;
    logic [15:0] old;
    core_state_t r;
    k = widx(sh_started ? sh_pc : sh_start_pc);
    old = sh_mem[k];
    sh_mem[k] = word;
    r = core_step(CMD_EXEC, '0, '0, 0);
    sh_mem[k] = old;
    return r.pc == 16'h0000;
  endfunction

  // place an instruction at the pc, then execute it; steer clear of a halt
  task automatic patch_and_run(logic [15:0] word);
    int unsigned k;
    while (lands_on_zero(word)) word = 16'($urandom);
    k = widx(sh_started ? sh_pc : sh_start_pc);
    queue_item(CMD_LOAD, 15'(k), word);
    queue_item(CMD_EXEC, 15'($urandom), 16'($urandom));
  endtask

  task automatic run_in_place();
    logic [15:0] word;
    word = sh_mem[widx(sh_started ? sh_pc : sh_start_pc)];
    if (lands_on_zero(word)) patch_and_run(word);
    else queue_item(CMD_EXEC, 15'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && awaited_q.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_start_pc(logic [15:0] v);
    @(negedge clk);
    start_pc_we <= 1'b1;
    start_pc_wdata <= v;
    @(negedge clk);
    start_pc_we <= 1'b0;
    sh_start_pc = v;
  endtask

  // input side: present items from the queue after each one's idle gap
  always @(negedge clk) begin : feed
    bit nv;
    nv = in_ch.valid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_fire) nv = 1'b0;
      if (!nv && pending_q.size() > 0) begin
        if (pending_q[0].gap > 0) begin
          pending_q[0].gap--;
        end else begin
          in_ch.cmd <= pending_q[0].cmd;
          in_ch.mem_word_address <= pending_q[0].wa;
          in_ch.mem_word_data <= pending_q[0].wd;
          void'(pending_q.pop_front());
          nv = 1'b1;
        end
      end
    end
    in_ch.valid <= nv;
  end

  // output side: random stall after every transfer, none in the calm phase
  always @(negedge clk) begin
    if (out_fire) rdy_wait = calm ? 0 : $urandom_range(0, 15);
    if (rdy_wait == 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      rdy_wait--;
    end
  end

  // sample both channels, check each result against the oldest prediction
  always @(posedge clk) begin : watch
    core_state_t want, got;
    in_fire = !rst && in_ch.valid && in_ch.ready;
    out_fire = !rst && out_ch.valid && out_ch.ready;
    if (out_fire) begin
      got.pc = out_ch.program_counter; got.cc = out_ch.cond_codes;
      got.halted = out_ch.halted; got.count = out_ch.executed_count;
      got.wr = out_ch.reg_written; got.ri = out_ch.reg_index; got.rv = out_ch.reg_value;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pc=%h", got.pc);
      end else begin
        want = awaited_q.pop_front();
        if (got.pc !== want.pc || got.cc !== want.cc || got.halted !== want.halted ||
            got.count !== want.count || got.wr !== want.wr || got.ri !== want.ri ||
            got.rv !== want.rv) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp pc=%h cc=%b h=%b n=%0d w=%b r%0d=%h,",
                     want.pc, want.cc, want.halted, want.count, want.wr, want.ri, want.rv,
                     " got pc=%h cc=%b h=%b n=%0d w=%b r%0d=%h",
                     got.pc, got.cc, got.halted, got.count, got.wr, got.ri, got.rv);
        end
      end
    end
    // watchdog on cycles without any transfer
    if (in_fire || out_fire) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int target;
    int unsigned pick;
    rst = 1'b1;
    start_pc_we = 1'b0;
    start_pc_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.mem_word_address = '0;
    in_ch.mem_word_data = '0;
    out_ch.ready = 1'b0;
    foreach (sh_mem[i]) sh_mem[i] = '0;
    foreach (sh_regs[i]) sh_regs[i] = '0;
    sh_pc = '0; sh_nzp = CC_RESET; sh_halt = 0; sh_started = 0;
    sh_count = '0; sh_start_pc = '0;
    calm = 0; mismatches = 0; idle_cycles = 0; rdy_wait = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait (in_ch.ready === 1'b1);

    // start pc zero while only loading, nothing runs yet
    set_start_pc(16'h0000);
    queue_item(CMD_LOAD, 15'h0000, 16'hFFFF);
    queue_item(CMD_LOAD, 15'h7FFF, 16'h0000);
    queue_item(CMD_LOAD, 15'h2AAA, 16'h5555);
    queue_item(CMD_LOAD, 15'h5555, 16'hAAAA);
    queue_item(CMD_LOAD, 15'd255, 16'h3000);  // trap vector
    drain();

    // directed run from the top of the address space
    set_start_pc(16'hFFFE);
    patch_and_run({OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10});             // add with -16
    patch_and_run({OP_ADD, 3'd3, 3'd1, 1'b0, 2'b00, 3'd1});        // add registers
    patch_and_run({OP_AND, 3'd4, 3'd1, 1'b1, 5'h0F});
    patch_and_run({OP_XOR, 3'd6, 3'd1, 1'b1, 5'h1F});              // not
    patch_and_run({OP_SHF, 3'd2, 3'd1, 2'b00, 4'd15});             // lshf by 15
    patch_and_run({OP_SHF, 3'd2, 3'd3, 2'b11, 4'd15});             // rshfa of a negative
    patch_and_run({OP_LEA, 3'd5, 9'h100});
    patch_and_run({OP_LDB, 3'd4, 3'd5, 6'h1F});                    // odd byte
    patch_and_run({OP_STW, 3'd1, 3'd5, 6'h20});
    patch_and_run({OP_BR, 3'd0, 9'h0FF});                          // no condition bits
    patch_and_run({OP_JSR, 1'b1, 11'h400});                        // most negative offset
    patch_and_run({OP_TRAP, 4'h0, 8'hFF});
    patch_and_run({OP_RSV8, 12'h000});
    patch_and_run({OP_RSV10, 12'hFFF});
    patch_and_run({OP_RSV11, 12'hABC});
    drain();

    // random phases, start pc rewritten each time (the core has started already)
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_start_pc(16'h0001);
        1: set_start_pc(16'h8000);
        default: set_start_pc(16'($urandom_range(0, 65534)));
      endcase
      calm = (ph == 2);
      target = pending_q.size() + 230;
      while (pending_q.size() < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) queue_item(CMD_LOAD, 15'($urandom), 16'($urandom));
        else if (pick < 30) run_in_place();
        else patch_and_run({4'($urandom_range(0, 15)), 12'($urandom)});
      end
      drain();
    end
    calm = 0;

    // force the pc to zero and show that the core stays halted
    patch_and_run({OP_AND, 3'd0, 3'd0, 1'b1, 5'h00});
    queue_item(CMD_LOAD, 15'(widx(sh_pc)), {OP_JMP, 3'd0, 3'd0, 6'h00});
    queue_item(CMD_EXEC, '0, '0);
    for (int i = 0; i < 12; i++) queue_item(1'($urandom), 15'($urandom), 16'($urandom));
    drain();

    if (mismatches == 0 && awaited_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
